@@ hw/rtl/overlap_add_crossfade_unit_defines.svh @@
// assertion macros for the overlap-add crossfade unit
// no dependencies; included by the files that carry assertions
`ifndef OVERLAP_ADD_CROSSFADE_UNIT_DEFINES_SVH
`define OVERLAP_ADD_CROSSFADE_UNIT_DEFINES_SVH

// same-cycle implication under synchronous reset
`define OAC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under synchronous reset
`define OAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/oac_pkg.sv @@
// shared types, widths and codes for the overlap-add crossfade unit
// no dependencies
package oac_pkg;

  localparam int SMP_W   = 24;
  localparam int POS_W   = 12;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int FADE_W  = 11;
  localparam int WGT_W   = 17;

  localparam int BUF_DEPTH_DEF  = 4096;
  localparam int PULSE_MAX_DEF  = 1024;
  localparam int FADE_TABLE_DEF = 1024;

  localparam logic [FADE_W-1:0] FADE_LIMIT_RST = FADE_W'(512);

  localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_COPY  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FADE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ADD   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } oac_div_stat_t;

endpackage

@@ hw/rtl/oac_in_if.sv @@
// request channel for the overlap-add crossfade unit
// depends on oac_pkg
interface oac_in_if import oac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [SMP_W-1:0]  pulse_sample;
  logic                     last_sample;
  logic [POS_W-1:0]         position;

  modport source (output valid, kind, pulse_sample, last_sample, position, input ready);
  modport sink   (input valid, kind, pulse_sample, last_sample, position, output ready);
endinterface

@@ hw/rtl/oac_out_if.sv @@
// result channel for the overlap-add crossfade unit
// depends on oac_pkg
interface oac_out_if import oac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SMP_W-1:0]  read_data;
  logic [STAT_W-1:0]        merge_status;
  logic                     is_read;

  modport source (output valid, read_data, merge_status, is_read, input ready);
  modport sink   (input valid, read_data, merge_status, is_read, output ready);
endinterface

@@ hw/rtl/oac_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module oac_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ hw/rtl/oac_weight_rom.sv @@
// raised-cosine fade weight rom, unsigned q1.16, built at elaboration
// depends on oac_pkg
module oac_weight_rom import oac_pkg::*; #(
  parameter int FADE_TABLE = FADE_TABLE_DEF
) (
  input  logic                          clk,
  input  logic                          re,
  input  logic [$clog2(FADE_TABLE)-1:0] addr,
  output logic [WGT_W-1:0]              rdata
);
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [WGT_W-1:0] wtab_t [FADE_TABLE];

  function automatic logic [WGT_W-1:0] half_w(input int unsigned k);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    theta = (longint'(k) * PI_Q30 + longint'((FADE_TABLE - 1) / 2)) / (FADE_TABLE - 1);
    t2    = (theta * theta) >> 30;
    term  = ONE_Q30;
    sum   = 0;
    term  = ((term * t2) >> 30) / 2;
    sum   = sum + longint'(term);
    term  = ((term * t2) >> 30) / 12;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 30;
    sum   = sum + longint'(term);
    term  = ((term * t2) >> 30) / 56;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 90;
    sum   = sum + longint'(term);
    term  = ((term * t2) >> 30) / 132;
    sum   = sum - longint'(term);
    term  = ((term * t2) >> 30) / 182;
    sum   = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    return WGT_W'((longint'(sum) + 64'sd16384) >>> 15);
  endfunction

  function automatic wtab_t build_tab();
    wtab_t t;
    for (int k = 0; k < FADE_TABLE; k++) begin
      if (2 * k <= FADE_TABLE - 1) begin
        t[k] = half_w(k);
      end else begin
        t[k] = WGT_W'(65536) - half_w(FADE_TABLE - 1 - k);
      end
    end
    return t;
  endfunction

  localparam wtab_t WTAB = build_tab();

  logic [WGT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= WTAB[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ hw/rtl/oac_index_div.sv @@
// restoring divider for the fade weight index, one quotient bit per cycle
// depends on oac_pkg
module oac_index_div import oac_pkg::*; #(
  parameter int NW = 22,
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] quot,
  output oac_div_stat_t stat
);
  localparam int SW = $clog2(QW);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dsh_r, dsh_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          fit;

  assign fit = rem_r >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = den << (QW - 1);
      q_nxt    = '0;
      cnt_nxt  = SW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fit ? rem_r - dsh_r : rem_r;
      q_nxt   = {q_r[QW-2:0], fit};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

@@ hw/rtl/overlap_add_crossfade_unit.sv @@
// Overlap-add unit: pulse samples go into a pulse store one per cycle; the sample marked
// last merges the pulse into the sample buffer (copy into an empty region, raised-cosine
// crossfade over the first L samples, saturating add for the rest) and returns a status.
// A read passes through a read-wait state and the done state before its result is issued.
// A clear holds off requests while it writes zero to every buffer word, and after reset
// the same clearing pass runs before the first request is taken. A merge scans the region
// with one buffer read per cycle, then takes each sample through a read and a write state,
// with the divider wait and a multiply state between them for each crossfaded sample of a
// crossfade longer than one sample, as set by the single buffer port pair and the
// bit-serial weight index divider, and issues the status last, held while a result is unread.
// depends on oac_pkg, oac_in_if, oac_out_if, oac_ram, oac_weight_rom, oac_index_div
`include "overlap_add_crossfade_unit_defines.svh"

module overlap_add_crossfade_unit import oac_pkg::*; #(
  parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
  parameter int PULSE_MAX  = PULSE_MAX_DEF,
  parameter int FADE_TABLE = FADE_TABLE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  oac_in_if.sink            in_ch,
  oac_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [FADE_W-1:0] cfg_wdata
);
  localparam int AW  = $clog2(BUF_DEPTH);
  localparam int PAW = $clog2(PULSE_MAX);
  localparam int CW  = $clog2(PULSE_MAX + 1);
  localparam int QW  = $clog2(FADE_TABLE);
  localparam int NW  = PAW + QW + 2;
  localparam int M1  = (POS_W > AW + 1) ? POS_W : AW + 1;
  localparam int EW  = ((M1 > CW) ? M1 : CW) + 1;
  localparam int LW  = (FADE_W > CW) ? FADE_W : CW;
  localparam logic [NW-1:0] NSTEP = NW'(2 * (FADE_TABLE - 1));
  localparam logic [QW-1:0] JMAX  = QW'(FADE_TABLE - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_RDW      = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SCAN_END = 4'd4;
  localparam logic [3:0] S_EL_RD    = 4'd5;
  localparam logic [3:0] S_EL_DIV   = 4'd6;
  localparam logic [3:0] S_EL_MUL   = 4'd7;
  localparam logic [3:0] S_EL_WR    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  localparam logic [1:0] M_COPY = 2'd0;
  localparam logic [1:0] M_ADD  = 2'd1;
  localparam logic [1:0] M_FADE = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [FADE_W-1:0] fade_limit_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     lfd_r, lfd_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              chk_r, chk_nxt;
  logic              busy_r, busy_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [NW-1:0]     num_r, num_nxt;
  logic              rd_oor_r, rd_oor_nxt;
  logic signed [SMP_W-1:0] res_data_r, res_data_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              res_rd_r, res_rd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic              out_rd_r, out_rd_nxt;
  logic signed [41:0] prod_old_r, prod_new_r;

  logic              acc_in;
  logic              store_ok;
  logic [CW-1:0]     n_new;
  logic [EW-1:0]     pos_e, end_e, clip_e, buf_e;
  logic [CW-1:0]     reg_len;
  logic [LW-1:0]     lmin_a, lmin;
  logic              region_ok;
  logic [EW-1:0]     addr_e;

  logic              buf_we, buf_re;
  logic [AW-1:0]     buf_waddr, buf_raddr;
  logic [SMP_W-1:0]  buf_wdata, buf_rdata;
  logic              pls_re;
  logic [SMP_W-1:0]  pls_rdata;
  logic              rom_re;
  logic [WGT_W-1:0]  rom_rdata;
  logic              div_start;
  logic [QW-1:0]     div_quot, jidx;
  oac_div_stat_t     div_st;

  logic signed [SMP_W-1:0] old_s, new_s, el_val;
  logic signed [SMP_W:0]   sum_s;
  logic signed [SMP_W-1:0] sat_s;
  logic signed [42:0]      acc_f;
  logic signed [26:0]      q_f;
  logic signed [SMP_W-1:0] fade_s;
  logic [WGT_W-1:0]        inv_w;
  logic                    in_fade;

  oac_ram #(.DEPTH(BUF_DEPTH), .WIDTH(SMP_W)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .re(buf_re), .raddr(buf_raddr), .rdata(buf_rdata)
  );

  oac_ram #(.DEPTH(PULSE_MAX), .WIDTH(SMP_W)) u_pulse (
    .clk(clk), .we(acc_in && in_ch.kind == KIND_PULSE && store_ok),
    .waddr(cnt_r[PAW-1:0]), .wdata(in_ch.pulse_sample),
    .re(pls_re), .raddr(idx_r[PAW-1:0]), .rdata(pls_rdata)
  );

  oac_weight_rom #(.FADE_TABLE(FADE_TABLE)) u_rom (
    .clk(clk), .re(rom_re), .addr(jidx), .rdata(rom_rdata)
  );

  oac_index_div #(.NW(NW), .QW(QW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r),
    .den({lfd_r - CW'(1), 1'b0} & NW'({(CW + 1){1'b1}})), .quot(div_quot), .stat(div_st)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign store_ok    = cnt_r < CW'(PULSE_MAX);
  assign n_new       = store_ok ? cnt_r + CW'(1) : cnt_r;
  assign pos_e       = EW'(in_ch.position);
  assign buf_e       = EW'(BUF_DEPTH);
  assign end_e       = pos_e + EW'(n_new);
  assign clip_e      = (end_e > buf_e) ? buf_e : end_e;
  assign reg_len     = CW'(clip_e - pos_e);
  assign region_ok   = (n_new != '0) && (pos_e < buf_e);
  assign lmin_a      = (LW'(fade_limit_r) < LW'(n_new)) ? LW'(fade_limit_r) : LW'(n_new);
  assign lmin        = (lmin_a < LW'(reg_len)) ? lmin_a : LW'(reg_len);
  assign addr_e      = EW'(pos_r) + EW'(idx_r);
  assign jidx        = (div_quot > JMAX) ? JMAX : div_quot;

  // element datapath
  assign old_s   = $signed(buf_rdata);
  assign new_s   = $signed(pls_rdata);
  assign sum_s   = {old_s[SMP_W-1], old_s} + {new_s[SMP_W-1], new_s};
  assign sat_s   = (sum_s > 25'sd8388607)  ? 24'sh7FFFFF :
                   (sum_s < -25'sd8388608) ? 24'sh800000 : sum_s[SMP_W-1:0];
  assign inv_w   = WGT_W'(65536) - rom_rdata;
  assign acc_f   = 43'(prod_old_r) + 43'(prod_new_r) + 43'sd32768;
  assign q_f     = 27'(acc_f >>> 16);
  assign fade_s  = (q_f > 27'sd8388607)  ? 24'sh7FFFFF :
                   (q_f < -27'sd8388608) ? 24'sh800000 : q_f[SMP_W-1:0];
  assign in_fade = (mode_r == M_FADE) && (idx_r < lfd_r);

  always_comb begin
    unique case (mode_r)
      M_COPY:  el_val = new_s;
      M_ADD:   el_val = sat_s;
      default: el_val = !in_fade ? sat_s : (lfd_r == CW'(1)) ? new_s : fade_s;
    endcase
  end

  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = addr_e[AW-1:0];
    buf_wdata = el_val;
    buf_re    = 1'b0;
    buf_raddr = addr_e[AW-1:0];
    pls_re    = 1'b0;
    rom_re    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_CLR: begin
        buf_we    = 1'b1;
        buf_waddr = clr_r;
        buf_wdata = '0;
      end
      S_IDLE: begin
        buf_re    = acc_in && in_ch.kind == KIND_READ;
        buf_raddr = pos_e[AW-1:0];
      end
      S_SCAN: begin
        buf_re = 1'b1;
      end
      S_EL_RD: begin
        buf_re    = 1'b1;
        pls_re    = 1'b1;
        div_start = in_fade && lfd_r != CW'(1);
      end
      S_EL_DIV: begin
        rom_re = div_st.done;
      end
      S_EL_WR: begin
        buf_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    lfd_nxt       = lfd_r;
    idx_nxt       = idx_r;
    chk_nxt       = 1'b0;
    busy_nxt      = busy_r;
    mode_nxt      = mode_r;
    num_nxt       = num_r;
    rd_oor_nxt    = rd_oor_r;
    res_data_nxt  = res_data_r;
    res_stat_nxt  = res_stat_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_rd_nxt    = out_rd_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          unique case (in_ch.kind)
            KIND_PULSE: begin
              cnt_nxt = n_new;
              if (in_ch.last_sample) begin
                cnt_nxt      = '0;
                pos_nxt      = in_ch.position;
                len_nxt      = reg_len;
                lfd_nxt      = CW'(lmin);
                idx_nxt      = '0;
                busy_nxt     = 1'b0;
                res_data_nxt = '0;
                res_rd_nxt   = 1'b0;
                res_stat_nxt = ST_NONE;
                state_nxt    = region_ok ? S_SCAN : S_DONE;
              end
            end
            KIND_READ: begin
              rd_oor_nxt   = !(pos_e < buf_e);
              res_stat_nxt = ST_NONE;
              res_rd_nxt   = 1'b1;
              state_nxt    = S_RDW;
            end
            KIND_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(BUF_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDW: begin
        res_data_nxt = rd_oor_r ? '0 : $signed(buf_rdata);
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        chk_nxt  = 1'b1;
        busy_nxt = busy_r || (chk_r && buf_rdata != '0);
        idx_nxt  = idx_r + CW'(1);
        if (idx_r == len_r - CW'(1)) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        idx_nxt   = '0;
        num_nxt   = NW'(lfd_r - CW'(1));
        state_nxt = S_EL_RD;
        if (!(busy_r || (chk_r && buf_rdata != '0))) begin
          mode_nxt     = M_COPY;
          res_stat_nxt = ST_COPY;
        end else if (lfd_r == '0) begin
          mode_nxt     = M_ADD;
          res_stat_nxt = ST_ADD;
        end else begin
          mode_nxt     = M_FADE;
          res_stat_nxt = ST_FADE;
        end
      end
      S_EL_RD: begin
        state_nxt = (in_fade && lfd_r != CW'(1)) ? S_EL_DIV : S_EL_WR;
      end
      S_EL_DIV: begin
        if (div_st.done) begin
          state_nxt = S_EL_MUL;
        end
      end
      S_EL_MUL: begin
        state_nxt = S_EL_WR;
      end
      S_EL_WR: begin
        idx_nxt = idx_r + CW'(1);
        num_nxt = num_r + NSTEP;
        state_nxt = (idx_r == len_r - CW'(1)) ? S_DONE : S_EL_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_stat_nxt  = res_stat_r;
          out_rd_nxt    = res_rd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    len_r      <= len_nxt;
    lfd_r      <= lfd_nxt;
    idx_r      <= idx_nxt;
    busy_r     <= busy_nxt;
    mode_r     <= mode_nxt;
    num_r      <= num_nxt;
    rd_oor_r   <= rd_oor_nxt;
    res_data_r <= res_data_nxt;
    res_stat_r <= res_stat_nxt;
    res_rd_r   <= res_rd_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
    out_rd_r   <= out_rd_nxt;
    prod_old_r <= old_s * $signed({1'b0, inv_w});
    prod_new_r <= new_s * $signed({1'b0, rom_rdata});
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      cnt_r        <= '0;
      chk_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      fade_limit_r <= FADE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        fade_limit_r <= cfg_wdata;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_data_r;
  assign out_ch.merge_status = out_stat_r;
  assign out_ch.is_read      = out_rd_r;

  `OAC_ASSERT_SAME(a_no_write_in_scan, clk, rst_n, (state_r == S_SCAN || state_r == S_SCAN_END), !buf_we, "buffer written during region scan")
  `OAC_ASSERT_SAME(a_elem_in_region, clk, rst_n, (state_r == S_EL_WR), (idx_r < len_r), "element index beyond region")
  `OAC_ASSERT_SAME(a_div_done_state, clk, rst_n, div_st.done, (state_r == S_EL_DIV), "divider finished outside its wait state")
  `OAC_ASSERT_SAME(a_div_busy_state, clk, rst_n, div_st.busy, (state_r == S_EL_DIV), "divider running outside its wait state")
  `OAC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, (cnt_r <= CW'(PULSE_MAX)), "pulse count above store depth")
  `OAC_ASSERT_NEXT(a_done_to_idle, clk, rst_n, (state_r == S_DONE && (!out_valid_r || out_ch.ready)), (state_r == S_IDLE && out_valid_r), "result not issued on completion")
endmodule

@@ tb/tb_overlap_add_crossfade_unit.sv @@
// testbench for overlap_add_crossfade_unit: random and directed requests, results checked
// against an in-bench model of the sample buffer, pulse store and crossfade arithmetic
// depends on oac_pkg, oac_in_if, oac_out_if and the unit itself
`timescale 1ns / 100ps

module tb_overlap_add_crossfade_unit;
  import oac_pkg::*;

  localparam int BUFN = BUF_DEPTH_DEF;
  localparam int PMAX = PULSE_MAX_DEF;
  localparam int TBL = FADE_TABLE_DEF;
  localparam int SETTLE = 5000;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic signed [SMP_W-1:0] smp;
    logic last;
    logic [POS_W-1:0] pos;
  } req_t;

  typedef struct {
    logic signed [SMP_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic is_read;
  } res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FADE_W-1:0] cfg_wdata;

  oac_in_if in_ch();
  oac_out_if out_ch();

  overlap_add_crossfade_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  req_t pending[$];
  res_t awaiting[$];
  int errors = 0;
  bit took = 0;
  bit calm = 0;
  bit hold_send = 0;
  int stall_left = 0;
  longint cycles = 0;

  int signed sbuf[BUFN];
  int signed pstore[PMAX];
  int unsigned pcount = 0;
  int unsigned fade_lim = 512;
  int unsigned wtab[TBL];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int unsigned half_wt(int unsigned k);
    longint unsigned theta, t2, term;
    longint sum;
    theta = (64'(k) * 64'd3373259426 + (TBL - 1) / 2) / (TBL - 1);
    t2 = (theta * theta) >> 30;
    term = 64'd1 << 30;
    sum = 0;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum += longint'(term);
      else sum -= longint'(term);
    end
    if (sum < 0) sum = 0;
    return int'((longint'(sum) + 16384) >>> 15);
  endfunction

  function automatic int signed sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic int signed blend(int signed old, int signed nw, int unsigned w);
    longint acc;
    acc = longint'(old) * longint'(65536 - w) + longint'(nw) * longint'(w) + 32768;
    return sat24(acc >>> 16);
  endfunction

  function automatic logic [STAT_W-1:0] overlap_add(int unsigned p, int unsigned n);
    int unsigned stop, r, l, w;
    longint unsigned j;
    bit occupied;
    if (n == 0 || p >= BUFN) return ST_NONE;
    stop = (p + n > BUFN) ? BUFN : p + n;
    r = stop - p;
    occupied = 0;
    for (int unsigned i = p; i < stop; i++) if (sbuf[i] != 0) occupied = 1;
    if (!occupied) begin
      for (int unsigned i = 0; i < r; i++) sbuf[p + i] = pstore[i];
      return ST_COPY;
    end
    l = fade_lim;
    if (l > n) l = n;
    if (l > r) l = r;
    for (int unsigned i = 0; i < l; i++) begin
      if (l == 1) w = 65536;
      else begin
        j = (64'd2 * i * (TBL - 1) + (l - 1)) / (64'd2 * (l - 1));
        if (j > TBL - 1) j = TBL - 1;
        w = wtab[j];
      end
      sbuf[p + i] = blend(sbuf[p + i], pstore[i], w);
    end
    for (int unsigned i = l; i < r; i++) sbuf[p + i] = sat24(longint'(sbuf[p + i]) + pstore[i]);
    return (l == 0) ? ST_ADD : ST_FADE;
  endfunction

  function automatic void apply_request(req_t q);
    res_t e;
    if (q.kind == KIND_PULSE) begin
      if (pcount < PMAX) begin
        pstore[pcount] = q.smp;
        pcount++;
      end
      if (q.last) begin
        e.data = '0;
        e.status = overlap_add(q.pos, pcount);
        e.is_read = 1'b0;
        pcount = 0;
        awaiting.insert(awaiting.size(), e);
      end
    end else if (q.kind == KIND_READ) begin
      e.data = (q.pos < BUFN) ? SMP_W'(sbuf[q.pos]) : '0;
      e.status = ST_NONE;
      e.is_read = 1'b1;
      awaiting.insert(awaiting.size(), e);
    end else if (q.kind == KIND_CLEAR) begin
      foreach (sbuf[i]) sbuf[i] = 0;
    end
  endfunction

  task automatic report(input string what, input res_t got, input res_t want);
    errors++;
    $display("mismatch %s: got data %0d status %0d read %0b, want data %0d status %0d read %0b",
             what, got.data, got.status, got.is_read, want.data, want.status, want.is_read);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      apply_request(pending[0]);
      pending.pop_front();
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (!in_ch.valid || took) begin
      took = 0;
      if (rst_n && pending.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 11)) begin
        in_ch.valid <= 1'b1;
        in_ch.kind <= pending[0].kind;
        in_ch.pulse_sample <= pending[0].smp;
        in_ch.last_sample <= pending[0].last;
        in_ch.position <= pending[0].pos;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data = out_ch.read_data;
      got.status = out_ch.merge_status;
      got.is_read = out_ch.is_read;
      if (awaiting.size() == 0) begin
        report("unexpected result", got, '{default: '0});
      end else begin
        if (got.is_read !== awaiting[0].is_read) report("is_read", got, awaiting[0]);
        else if (got.status !== awaiting[0].status) report("merge_status", got, awaiting[0]);
        else if (got.data !== awaiting[0].data) report("read_data", got, awaiting[0]);
        void'(awaiting.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [SMP_W-1:0] rand_smp();
    case ($urandom_range(7))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic push(input logic [KIND_W-1:0] k, input logic signed [SMP_W-1:0] s,
                      input logic l, input logic [POS_W-1:0] p);
    req_t q;
    q.kind = k; q.smp = s; q.last = l; q.pos = p;
    pending.insert(pending.size(), q);
  endtask

  task automatic send_pulse(input int n, input int p, input logic signed [SMP_W-1:0] v);
    for (int i = 0; i < n; i++) begin
      push(KIND_PULSE, (v === 'x) ? rand_smp() : v, i == n - 1, POS_W'(p));
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || awaiting.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_fade(input int unsigned v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= FADE_W'(v);
    fade_lim = v & 11'h7ff;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  int unsigned fades[8] = '{0, 1, 2, 1024, 2047, 16, 3, 512};

  initial begin
    int base, n;
    bit waited;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PULSE;
    in_ch.pulse_sample = '0;
    in_ch.last_sample = 1'b0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;
    waited = 0;
    foreach (sbuf[i]) sbuf[i] = 0;
    foreach (pstore[i]) pstore[i] = 0;
    for (int k = 0; k < TBL; k++) begin
      if (2 * k <= TBL - 1) wtab[k] = half_wt(k);
      else wtab[k] = 65536 - half_wt(TBL - 1 - k);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: copy, single-sample fade, full-scale samples, past the end, ignored kind, clear
    send_pulse(1, 0, 24'sh123456);
    push(KIND_READ, '0, 1'b0, POS_W'(0));
    send_pulse(1, 0, -24'sd7);
    push(KIND_READ, '0, 1'b0, POS_W'(0));
    send_pulse(2, 0, 24'sh7fffff);
    send_pulse(3, 1, 24'sh7fffff);
    push(KIND_READ, '0, 1'b0, POS_W'(1));
    push(KIND_READ, '0, 1'b0, POS_W'(3));
    send_pulse(5, 4094, 24'sh800000);
    send_pulse(5, 4093, 24'sh800000);
    push(KIND_READ, '0, 1'b0, POS_W'(4095));
    push(KIND_UNUSED, 24'sh7fffff, 1'b1, 12'hfff);
    push(KIND_CLEAR, '0, 1'b0, POS_W'(0));
    push(KIND_READ, '0, 1'b0, POS_W'(4095));
    push(KIND_READ, '0, 1'b0, POS_W'(0));
    drain();

    // pulse store overflow, then a long crossfade over it
    send_pulse(PMAX + 6, 100, 'x);
    send_pulse(40, 120, 'x);
    push(KIND_READ, '0, 1'b0, POS_W'(130));
    drain();

    foreach (fades[ph]) begin
      set_fade(ph == 6 ? $urandom_range(2047) : fades[ph]);
      calm = (ph == 2);
      if (ph == 3) stall_left = 3000;
      base = (ph % 3 == 0) ? 4040 : $urandom_range(3900);
      n = 0;
      while (n < 35) begin
        int r, len;
        r = $urandom_range(99);
        if (ph == 4 && !waited && n >= 15) begin
          waited = 1;
          while (pending.size() > 0) @(posedge clk);
          hold_send = 1;
          while (awaiting.size() > 0) @(posedge clk);
          repeat (20) @(posedge clk);
          hold_send = 0;
        end
        if (r < 70) begin
          len = ($urandom_range(19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
          send_pulse(len, base + $urandom_range(60), 'x);
          n += len;
        end else if (r < 88) begin
          push(KIND_READ, rand_smp(), 1'($urandom_range(1)),
               ($urandom_range(3) == 0) ? POS_W'($urandom) : POS_W'(base + $urandom_range(90)));
          n++;
        end else if (r < 91) begin
          push(KIND_CLEAR, rand_smp(), 1'($urandom_range(1)), POS_W'($urandom));
          n++;
        end else if (r < 95) begin
          push(KIND_UNUSED, rand_smp(), 1'($urandom_range(1)), POS_W'($urandom));
        end else begin
          push(KIND_PULSE, rand_smp(), 1'b1, POS_W'($urandom));
          n++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
